// ===== sv/dtti_pkg.sv =====
// ----------------------------------------------------------------------------
// dtti_pkg
// Shared types and constants for the decimal text to integer scanner.
// ----------------------------------------------------------------------------
package dtti_pkg;

  localparam int unsigned NumW      = 64;
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoAw    = $clog2(FifoDepth);
  localparam int unsigned TdataW    = 72;

  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;

  localparam logic KindNumber   = 1'b0;
  localparam logic KindBadStart = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_SIGN   = 2'd1,
    PH_DIGITS = 2'd2
  } phase_e;

  typedef struct packed {
    logic [NumW-1:0] number;
    logic            kind;
    logic            failed;
    logic            last;
  } res_t;

  typedef struct packed {
    logic [1:0] count;
    res_t       r1;
    res_t       r0;
  } scan_res_t;

  function automatic logic [NumW-1:0] wrap_width(logic [NumW-1:0] v, logic wide);
    logic [NumW-1:0] r;
    r = wide ? v : {{(NumW-32){v[31]}}, v[31:0]};
    return r;
  endfunction

endpackage

// ===== sv/dtti_scan.sv =====
// ----------------------------------------------------------------------------
// dtti_scan
// Token state and single-pass digit accumulate / number finish for one byte.
// ----------------------------------------------------------------------------
module dtti_scan (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic [7:0]           byte_i,
  input  logic                 wide_i,
  output dtti_pkg::scan_res_t  res_o
);

  dtti_pkg::phase_e phase_q, phase_d;
  logic                      neg_q, neg_d;
  logic [dtti_pkg::NumW-1:0] acc_q, acc_d;
  logic                      fail_q, fail_d;

  logic                      is_digit, is_ws, in_num, bad;
  logic [3:0]                dval;
  logic [dtti_pkg::NumW-1:0] acc_mul, acc_w, min_v, fin_v;
  logic                      fin_fail;

  assign is_digit = (byte_i >= dtti_pkg::ChZero) && (byte_i <= dtti_pkg::ChNine);
  assign is_ws    = (byte_i == dtti_pkg::ChNul) || (byte_i == dtti_pkg::ChSpace) ||
                    (byte_i == dtti_pkg::ChTab) || (byte_i == dtti_pkg::ChLf);
  assign dval     = byte_i[3:0];
  assign in_num   = (phase_q == dtti_pkg::PH_SIGN) || (phase_q == dtti_pkg::PH_DIGITS);
  assign bad      = !is_ws && !is_digit && (byte_i != dtti_pkg::ChPlus) &&
                    (byte_i != dtti_pkg::ChMinus);

  // acc*10 - digit
  assign acc_mul = {acc_q[dtti_pkg::NumW-4:0], 3'b000} + {acc_q[dtti_pkg::NumW-2:0], 1'b0}
                   - {{(dtti_pkg::NumW-4){1'b0}}, dval};

  assign acc_w = dtti_pkg::wrap_width(acc_q, wide_i);
  assign min_v = wide_i ? {1'b1, {(dtti_pkg::NumW-1){1'b0}}}
                        : {{(dtti_pkg::NumW-31){1'b1}}, 31'd0};

  always_comb begin
    fin_fail = 1'b0;
    fin_v    = acc_w;
    if (!neg_q) begin
      if (acc_w == min_v) begin
        fin_fail = 1'b1;
      end else begin
        fin_v = dtti_pkg::wrap_width(-acc_w, wide_i);
      end
    end
  end

  // next phase
  always_comb begin
    phase_d = dtti_pkg::PH_IDLE;
    if (in_num && is_digit) begin
      phase_d = dtti_pkg::PH_DIGITS;
    end else if (is_digit) begin
      phase_d = dtti_pkg::PH_DIGITS;
    end else if ((byte_i == dtti_pkg::ChPlus) || (byte_i == dtti_pkg::ChMinus)) begin
      phase_d = dtti_pkg::PH_SIGN;
    end
  end

  // datapath and results
  always_comb begin
    neg_d        = 1'b0;
    acc_d        = '0;
    fail_d       = fail_q;
    res_o        = '0;
    if (in_num && is_digit) begin
      neg_d = neg_q;
      acc_d = dtti_pkg::wrap_width(acc_mul, wide_i);
    end else begin
      if (in_num) begin
        fail_d              = fail_q | fin_fail;
        res_o.r0.number     = fin_v;
        res_o.r0.kind       = dtti_pkg::KindNumber;
        res_o.r0.failed     = fail_q | fin_fail;
        res_o.r0.last       = !bad;
      end
      if (byte_i == dtti_pkg::ChMinus) begin
        neg_d = 1'b1;
      end else if (is_digit) begin
        acc_d = dtti_pkg::wrap_width(-{{(dtti_pkg::NumW-4){1'b0}}, dval}, wide_i);
      end
      if (bad) begin
        fail_d = 1'b1;
        if (in_num) begin
          res_o.r1 = '{number: '0, kind: dtti_pkg::KindBadStart, failed: 1'b1, last: 1'b1};
        end else begin
          res_o.r0 = '{number: '0, kind: dtti_pkg::KindBadStart, failed: 1'b1, last: 1'b1};
        end
      end
      res_o.count = {1'b0, in_num} + {1'b0, bad};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= dtti_pkg::PH_IDLE;
      neg_q   <= 1'b0;
      acc_q   <= '0;
      fail_q  <= 1'b0;
    end else if (en_i) begin
      phase_q <= phase_d;
      neg_q   <= neg_d;
      acc_q   <= acc_d;
      fail_q  <= fail_d;
    end
  end

endmodule

// ===== sv/dtti_out_fifo.sv =====
// ----------------------------------------------------------------------------
// dtti_out_fifo
// Four-entry result queue; takes up to two results a cycle, gives one.
// ----------------------------------------------------------------------------
module dtti_out_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  dtti_pkg::scan_res_t res_i,
  output logic                room_o,
  output logic                valid_o,
  input  logic                ready_i,
  output dtti_pkg::res_t      head_o
);

  dtti_pkg::res_t mem_q [dtti_pkg::FifoDepth];
  logic [dtti_pkg::FifoAw-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [dtti_pkg::FifoAw:0]   count_q, count_d;
  logic [1:0]                  n_push;
  logic                        pop;

  assign n_push  = push_i ? res_i.count : 2'd0;
  assign pop     = valid_o && ready_i;
  assign valid_o = (count_q != '0);
  assign room_o  = (count_q <= (dtti_pkg::FifoAw+1)'(dtti_pkg::FifoDepth - 2));
  assign head_o  = mem_q[rd_ptr_q];

  assign wr_ptr_d = wr_ptr_q + dtti_pkg::FifoAw'(n_push);
  assign rd_ptr_d = rd_ptr_q + dtti_pkg::FifoAw'(pop);
  assign count_d  = count_q + (dtti_pkg::FifoAw+1)'(n_push) - (dtti_pkg::FifoAw+1)'(pop);

  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) begin
      mem_q[wr_ptr_q] <= res_i.r0;
    end
    if (n_push == 2'd2) begin
      mem_q[wr_ptr_q + dtti_pkg::FifoAw'(1)] <= res_i.r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (n_push != 2'd0) |-> (count_q <= (dtti_pkg::FifoAw+1)'(dtti_pkg::FifoDepth - 2)))
    else $error("result queue overflow");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (dtti_pkg::FifoAw+1)'(dtti_pkg::FifoDepth))
    else $error("result count out of range");

  a_ptr_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q[dtti_pkg::FifoAw-1:0] == (wr_ptr_q - rd_ptr_q))
    else $error("queue pointers disagree with count");

endmodule

// ===== sv/decimal_text_to_integer.sv =====
// ----------------------------------------------------------------------------
// decimal_text_to_integer
// Scans signed decimal integers from a text byte stream.
// ----------------------------------------------------------------------------
//  channel   dir  beat contents
//  s_axis    in   tdata[7:0] text_byte
//  m_axis    out  tdata[63:0] number, tdata[64] failed; tuser kind; tlast last
//  cfg       in   data: width_mode
//
//  One byte per cycle while the queue has room; a byte is scanned while it
//  sits in the input register, and results leave one beat a cycle when taken.
//  The throughput limit is the result queue: a byte that ends a number and is
//  itself a bad start gives two beats, so such runs drain at one beat a cycle.
//  Reset clears token state, fail flag, width_mode and the queue.
//  Input is held off only when the queue has less than two free entries.
// ----------------------------------------------------------------------------
module decimal_text_to_integer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] text_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [dtti_pkg::TdataW-1:0] m_axis_tdata_o, // [63:0] number, [64] failed
  output logic        m_axis_tuser_o,   // [0] kind
  output logic        m_axis_tlast_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i        // width_mode
);

  logic                in_valid_q, in_valid_d;
  logic [7:0]          in_byte_q;
  logic                wide_q;
  logic                room, consume;
  dtti_pkg::scan_res_t scan_res;
  dtti_pkg::res_t      head;

  assign cfg_ready_o     = 1'b1;
  assign consume         = in_valid_q && room;
  assign s_axis_tready_o = !in_valid_q || consume;
  assign in_valid_d      = s_axis_tvalid_i || (in_valid_q && !consume);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      wide_q     <= 1'b0;
    end else begin
      if (s_axis_tready_o) begin
        in_valid_q <= s_axis_tvalid_i;
      end else begin
        in_valid_q <= in_valid_d;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        wide_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_byte_q <= s_axis_tdata_i;
    end
  end

  dtti_scan u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (consume),
    .byte_i (in_byte_q),
    .wide_i (wide_q),
    .res_o  (scan_res)
  );

  dtti_out_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (consume),
    .res_i   (scan_res),
    .room_o  (room),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .head_o  (head)
  );

  assign m_axis_tdata_o = {{(dtti_pkg::TdataW-dtti_pkg::NumW-1){1'b0}}, head.failed,
                           head.number};
  assign m_axis_tuser_o = head.kind;
  assign m_axis_tlast_o = head.last;

endmodule

// ===== dv/decimal_text_to_integer_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// decimal_text_to_integer_tb
// Drives text bytes into the integer scanner and checks every result beat
// against a cycle-free scan of the same bytes. A short directed part covers
// separators, signs with no digits, the zero byte, a width switch mid-number,
// the minimum value and a terminator that is itself a bad start. Random
// phases then mix well-formed numbers, boundary values and noise under both
// widths, with random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module decimal_text_to_integer_tb;

  localparam int DrainCycles = 10;
  localparam int CycleLimit  = 400000;
  localparam int PhaseBytes  = 100;
  localparam int NumPhases   = 8;

  logic                          clk_i           = 1'b0;
  logic                          rst_ni          = 1'b0;
  logic                          s_axis_tvalid_i = 1'b0;
  logic                          s_axis_tready_o;
  logic [7:0]                    s_axis_tdata_i  = '0;
  logic                          m_axis_tvalid_o;
  logic                          m_axis_tready_i = 1'b0;
  logic [dtti_pkg::TdataW-1:0]   m_axis_tdata_o;
  logic                          m_axis_tuser_o;
  logic                          m_axis_tlast_o;
  logic                          cfg_valid_i     = 1'b0;
  logic                          cfg_ready_o;
  logic                          cfg_data_i      = 1'b0;

  decimal_text_to_integer u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i)
  );

  // scanner state mirror
  dtti_pkg::phase_e          scan_phase  = dtti_pkg::PH_IDLE;
  logic                      neg_sign    = 1'b0;
  logic [dtti_pkg::NumW-1:0] digit_acc   = '0;
  logic                      sticky_fail = 1'b0;
  logic                      wide_mode   = 1'b0;

  logic [7:0]     text_q[$];
  dtti_pkg::res_t number_beats_q[$];

  int error_count = 0;
  int cycle_count = 0;
  int bytes_queued = 0;
  int gap_max = 0;
  int stall_mode = 0;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic logic [dtti_pkg::NumW-1:0] fit_width(logic [dtti_pkg::NumW-1:0] v);
    return wide_mode ? v : {{32{v[31]}}, v[31:0]};
  endfunction

  function automatic logic is_digit(logic [7:0] b);
    return (b >= dtti_pkg::ChZero) && (b <= dtti_pkg::ChNine);
  endfunction

  function automatic logic [dtti_pkg::NumW-1:0] close_number();
    logic [dtti_pkg::NumW-1:0] v;
    logic [dtti_pkg::NumW-1:0] lowest;
    v      = fit_width(digit_acc);
    lowest = wide_mode ? 64'h8000_0000_0000_0000 : 64'hFFFF_FFFF_8000_0000;
    if (!neg_sign) begin
      if (v == lowest) sticky_fail = 1'b1;
      else v = fit_width(-v);
    end
    scan_phase = dtti_pkg::PH_IDLE;
    neg_sign   = 1'b0;
    digit_acc  = '0;
    return v;
  endfunction

  task automatic scan_text_byte(logic [7:0] b);
    dtti_pkg::res_t beats[2];
    int             n;
    n = 0;
    if (scan_phase != dtti_pkg::PH_IDLE) begin
      if (is_digit(b)) begin
        digit_acc  = fit_width(digit_acc * 64'd10 - {56'd0, b - dtti_pkg::ChZero});
        scan_phase = dtti_pkg::PH_DIGITS;
        return;
      end
      beats[0].number = close_number();
      beats[0].kind   = dtti_pkg::KindNumber;
      beats[0].failed = sticky_fail;
      beats[0].last   = 1'b0;
      n = 1;
    end
    if (b == dtti_pkg::ChNul || b == dtti_pkg::ChSpace || b == dtti_pkg::ChTab ||
        b == dtti_pkg::ChLf) begin
    end else if (b == dtti_pkg::ChMinus || b == dtti_pkg::ChPlus) begin
      neg_sign   = (b == dtti_pkg::ChMinus);
      digit_acc  = '0;
      scan_phase = dtti_pkg::PH_SIGN;
    end else if (is_digit(b)) begin
      neg_sign   = 1'b0;
      digit_acc  = fit_width(-{56'd0, b - dtti_pkg::ChZero});
      scan_phase = dtti_pkg::PH_DIGITS;
    end else begin
      sticky_fail = 1'b1;
      beats[n].number = '0;
      beats[n].kind   = dtti_pkg::KindBadStart;
      beats[n].failed = sticky_fail;
      beats[n].last   = 1'b0;
      n++;
    end
    if (n > 0) beats[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) number_beats_q.push_back(beats[i]);
  endtask

  // sender: bursts of random length, random gaps between them
  int burst_left = 1;
  int gap_left   = 0;

  always @(posedge clk_i) begin : text_driver
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) scan_text_byte(s_axis_tdata_i);
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (gap_left != 0) begin
          gap_left--;
          s_axis_tvalid_i <= 1'b0;
        end else if (text_q.size() != 0) begin
          s_axis_tvalid_i <= 1'b1;
          s_axis_tdata_i  <= text_q.pop_front();
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 12);
            gap_left   = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
          end else begin
            burst_left--;
          end
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // receiver: no stalls, a rotating stall pattern or random stalls; checks each accepted beat
  logic [15:0] ready_pattern = 16'hF0F3;
  int          pattern_age   = 0;

  always @(posedge clk_i) begin : result_monitor
    dtti_pkg::res_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (number_beats_q.size() == 0) begin
        $error("unexpected result beat: number=%0d kind=%0d",
               $signed(m_axis_tdata_o[dtti_pkg::NumW-1:0]), m_axis_tuser_o);
        error_count++;
      end else begin
        want = number_beats_q.pop_front();
        if (m_axis_tdata_o[dtti_pkg::NumW-1:0] !== want.number) begin
          $error("number: expected %0d, got %0d", $signed(want.number),
                 $signed(m_axis_tdata_o[dtti_pkg::NumW-1:0]));
          error_count++;
        end
        if (m_axis_tuser_o !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, m_axis_tuser_o);
          error_count++;
        end
        if (m_axis_tdata_o[dtti_pkg::NumW] !== want.failed) begin
          $error("failed: expected %0d, got %0d", want.failed,
                 m_axis_tdata_o[dtti_pkg::NumW]);
          error_count++;
        end
        if (m_axis_tlast_o !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, m_axis_tlast_o);
          error_count++;
        end
      end
    end
    pattern_age++;
    if (pattern_age == 64) begin
      pattern_age   = 0;
      ready_pattern = 16'($urandom) | 16'h0101;
    end
    ready_pattern = {ready_pattern[14:0], ready_pattern[15]};
    if (!rst_ni) m_axis_tready_i <= 1'b0;
    else if (stall_mode == 0) m_axis_tready_i <= 1'b1;
    else if (stall_mode == 1) m_axis_tready_i <= ready_pattern[0];
    else m_axis_tready_i <= ($urandom_range(0, 3) == 0);
  end

  task automatic queue_byte(logic [7:0] b);
    text_q.push_back(b);
    bytes_queued++;
  endtask

  task automatic queue_text(string s);
    for (int i = 0; i < s.len(); i++) queue_byte(s[i]);
  endtask

  task automatic wait_drained();
    while (text_q.size() != 0 || s_axis_tvalid_i || number_beats_q.size() != 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_width_mode(logic mode);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= mode;
    do @(posedge clk_i); while (!cfg_ready_o);
    wide_mode = mode;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic queue_separator();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 6) queue_byte(dtti_pkg::ChSpace);
    else if (pick < 9) queue_byte(dtti_pkg::ChTab);
    else if (pick < 12) queue_byte(dtti_pkg::ChLf);
    else if (pick < 14) queue_byte(dtti_pkg::ChNul);
    else if (pick < 15) queue_byte(dtti_pkg::ChMinus);
    else if (pick < 16) queue_byte(dtti_pkg::ChPlus);
    else queue_byte(8'($urandom_range(8'h3A, 8'hFF)));
  endtask

  task automatic queue_random_token();
    int pick;
    int ndig;
    pick = $urandom_range(0, 99);
    if (pick < 78) begin
      case ($urandom_range(0, 3))
        0: queue_byte(dtti_pkg::ChMinus);
        1: queue_byte(dtti_pkg::ChPlus);
        default: ;
      endcase
      if (pick < 10) begin
        case ($urandom_range(0, 5))
          0: queue_text("2147483648");
          1: queue_text("2147483647");
          2: queue_text("4294967296");
          3: queue_text("9223372036854775808");
          4: queue_text("9223372036854775807");
          default: queue_text("18446744073709551616");
        endcase
      end else if (pick < 72) begin
        ndig = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 5) : $urandom_range(6, 22);
        if (pick < 14) ndig = 0;
        for (int i = 0; i < ndig; i++) begin
          queue_byte(8'($urandom_range(dtti_pkg::ChZero, dtti_pkg::ChNine)));
        end
      end
      ndig = $urandom_range(1, 2);
      for (int i = 0; i < ndig; i++) queue_separator();
    end else begin
      queue_byte(8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // separators, bare signs, zero byte
    queue_text("-7\t+\n9");
    queue_byte(dtti_pkg::ChNul);
    // width switch while digits are pending
    queue_text("123");
    wait_drained();
    write_width_mode(1'b1);
    queue_text("45 ");
    wait_drained();
    write_width_mode(1'b0);
    // 32-bit minimum without minus, ended by a bad start byte
    queue_text("2147483648");
    queue_byte(8'hFF);
    wait_drained();

    for (int p = 0; p < NumPhases; p++) begin
      write_width_mode(p[0] ^ p[2]);
      if (p == 0) begin
        gap_max    = 0;
        stall_mode = 0;
      end else begin
        gap_max    = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
        stall_mode = $urandom_range(0, 2);
      end
      bytes_queued = 0;
      while (bytes_queued < PhaseBytes) begin
        queue_random_token();
        @(posedge clk_i);
      end
      wait_drained();
    end

    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/dtti_pkg.sv
sv/dtti_scan.sv
sv/dtti_out_fifo.sv
sv/decimal_text_to_integer.sv
dv/decimal_text_to_integer_tb.sv
